[design/nbge_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbge_pkg: shared types and constants
// Request/result payloads, configuration bundle, sequencer states and codes
// for the direct-sum gravity Euler step block.
// ----------------------------------------------------------------------------
package nbge_pkg;

    localparam int MAX_BODIES = 1024;
    localparam int ADDR_W     = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);
    localparam int ENTRY_W    = 96;
    localparam int PADDR_W    = 4;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [1:0] REG_BODY_COUNT   = 2'd0;
    localparam logic [1:0] REG_GRAVITY_GAIN = 2'd1;
    localparam logic [1:0] REG_TIME_STEP    = 2'd2;

    typedef struct packed {
        logic               op;
        logic        [9:0]  body_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic        [31:0] body_mass_in;
    } nbge_req_t;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic               overflow_flag;
        logic               coincident_flag;
    } nbge_rsp_t;

    typedef struct packed {
        logic [10:0] body_count;
        logic [31:0] gravity_gain;
        logic [31:0] time_step;
    } nbge_cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NEXT,
        ST_DIFF,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_C,
        ST_GM,
        ST_ROOT,
        ST_DEN_A,
        ST_DEN_B,
        ST_DEN_C,
        ST_NUM_A,
        ST_NUM_B,
        ST_DIV,
        ST_ACC,
        ST_NUM_Y,
        ST_SAT,
        ST_VEL_X,
        ST_VEL_Y,
        ST_POS_X,
        ST_POS_Y,
        ST_POS_END,
        ST_OUT
    } nbge_state_t;

endpackage

[design/nbge_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbge_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nbge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/nbge_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbge_cfg: configuration registers
// APB-style register file for body count, gravity gain and time step.
// ----------------------------------------------------------------------------
module nbge_cfg
    import nbge_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output nbge_cfg_t          cfg
);

    nbge_cfg_t  cfg_reg;
    logic [1:0] reg_sel;
    logic       wr_en;

    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_BODY_COUNT:   cfg_reg.body_count   <= pwdata[10:0];
                REG_GRAVITY_GAIN: cfg_reg.gravity_gain <= pwdata;
                REG_TIME_STEP:    cfg_reg.time_step    <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_BODY_COUNT:   prdata = {21'd0, cfg_reg.body_count};
            REG_GRAVITY_GAIN: prdata = cfg_reg.gravity_gain;
            REG_TIME_STEP:    prdata = cfg_reg.time_step;
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[design/nbody_gravity_euler_step_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbody_gravity_euler_step_top: direct-sum 2-D gravity with Euler step
// Body table in RAM, one shared 32x32 multiplier, bit-serial square root and
// divider under a sequencer.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_stall  nbge_req_t
//   out      out  out_valid/out_stall nbge_rsp_t
//   cfg      in   APB psel/penable   32-bit registers at 0x0, 0x4, 0x8
//
// A load request writes its table entry. An update request walks the counted
// bodies, skipping its own index and coincident bodies, with a 32-step root and
// two 96-step divides per other body that share one unit.
// The block takes one request at a time; a finished result waits in the
// output register while the next request is taken.
// No clearing pass after reset; table entries are undefined until loaded.
// ----------------------------------------------------------------------------
module nbody_gravity_euler_step_top
    import nbge_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  nbge_req_t          in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output nbge_rsp_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic signed [51:0] SAT_MAX  = 52'sd2147483647;
    localparam logic signed [51:0] SAT_MIN  = -52'sd2147483648;
    localparam logic        [95:0] TERM_CAP = 96'd1 << 40;

    nbge_cfg_t   cfg;
    nbge_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    nbge_rsp_t   out_data_reg;

    logic               in_acc;
    logic               mem_we;
    logic [ENTRY_W-1:0] mem_rdata;

    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic        [9:0]  idx_reg;
    logic [CNT_W-1:0]   i_reg, lim_reg;
    logic [31:0]        ax_reg, ay_reg, mass_reg;
    logic               sh_reg, dxn_reg, dyn_reg, axis_reg, sgn_reg;
    logic [63:0]        prod_reg, r2_reg, gm_reg;
    logic [63:0]        sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [97:0]        den_reg, rem_reg;
    logic [95:0]        num_reg;
    logic [6:0]         cnt_reg;
    logic signed [51:0] acc_x_reg, acc_y_reg;
    logic signed [31:0] axo_reg, ayo_reg, nvx_reg, nvy_reg, npx_reg, npy_reg;
    logic               ovf_reg, coin_reg;

    logic signed [32:0] dx, dy;
    logic        [32:0] mx, my;
    logic               sh, coincident, own;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        sq_sum;
    logic               sq_ge;
    logic [98:0]        rem_sh, den_ext;
    logic               div_ge;
    logic               term_big;
    logic [51:0]        term;
    logic [51:0]        scaled;
    logic signed [51:0] sum_vx, sum_vy, sum_px, sum_py;
    logic signed [31:0] mem_x, mem_y;

    function automatic logic [31:0] sat32(input logic signed [51:0] v);
        logic [31:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[31:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[31:0];
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic is_sat(input logic signed [51:0] v);
        return (v > SAT_MAX) || (v < SAT_MIN);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    nbge_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign mem_we   = in_acc && (in_data.op == OP_LOAD)
                      && (32'(in_data.body_index) < MAX_BODIES);

    nbge_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BODIES)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ADDR_W'(in_data.body_index)),
        .wdata ({in_data.pos_x, in_data.pos_y, in_data.body_mass_in}),
        .raddr (ADDR_W'(i_reg)),
        .rdata (mem_rdata)
    );

    assign mem_x      = mem_rdata[95:64];
    assign mem_y      = mem_rdata[63:32];
    assign dx         = {mem_x[31], mem_x} - {px_reg[31], px_reg};
    assign dy         = {mem_y[31], mem_y} - {py_reg[31], py_reg};
    assign mx         = dx[32] ? 33'(-dx) : 33'(dx);
    assign my         = dy[32] ? 33'(-dy) : 33'(dy);
    assign sh         = mx[32] | mx[31] | my[32] | my[31];
    assign coincident = (dx == 33'sd0) && (dy == 33'sd0);
    assign own        = (32'(i_reg) == 32'(idx_reg));

    assign sq_sum  = sq_res_reg + sq_bit_reg;
    assign sq_ge   = (sq_v_reg >= sq_sum);
    assign rem_sh  = {rem_reg, num_reg[95]};
    assign den_ext = {1'b0, den_reg};
    assign div_ge  = (rem_sh >= den_ext);

    assign term_big = (num_reg > TERM_CAP);
    assign term     = term_big ? 52'(TERM_CAP) : 52'(num_reg[40:0]);

    assign scaled = 52'(prod_reg[63:16]);
    assign sum_vx = sgn_reg ? 52'(vx_reg) - scaled : 52'(vx_reg) + scaled;
    assign sum_vy = sgn_reg ? 52'(vy_reg) - scaled : 52'(vy_reg) + scaled;
    assign sum_px = sgn_reg ? 52'(px_reg) - scaled : 52'(px_reg) + scaled;
    assign sum_py = sgn_reg ? 52'(py_reg) - scaled : 52'(py_reg) + scaled;

    always_comb
    begin
        case (state_reg)
            ST_SQ_A:  begin mul_a = ax_reg;            mul_b = ax_reg;            end
            ST_SQ_B:  begin mul_a = ay_reg;            mul_b = ay_reg;            end
            ST_SQ_C:  begin mul_a = cfg.gravity_gain;  mul_b = mass_reg;          end
            ST_DEN_A: begin mul_a = r2_reg[31:0];      mul_b = sq_res_reg[31:0];  end
            ST_DEN_B: begin mul_a = r2_reg[63:32];     mul_b = sq_res_reg[31:0];  end
            ST_DEN_C: begin mul_a = gm_reg[31:0];      mul_b = ax_reg;            end
            ST_NUM_Y: begin mul_a = gm_reg[31:0];      mul_b = ay_reg;            end
            ST_NUM_A:
            begin
                mul_a = gm_reg[63:32];
                mul_b = axis_reg ? ay_reg : ax_reg;
            end
            ST_VEL_X: begin mul_a = mag32(axo_reg);    mul_b = cfg.time_step;     end
            ST_VEL_Y: begin mul_a = mag32(ayo_reg);    mul_b = cfg.time_step;     end
            ST_POS_X: begin mul_a = mag32(nvx_reg);    mul_b = cfg.time_step;     end
            ST_POS_Y: begin mul_a = mag32(nvy_reg);    mul_b = cfg.time_step;     end
            default:  begin mul_a = 32'd0;             mul_b = 32'd0;             end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_data.op == OP_UPDATE))
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (i_reg >= lim_reg)
                begin
                    state_next = ST_SAT;
                end
                else if (!own)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:    state_next = coincident ? ST_NEXT : ST_SQ_A;
            ST_SQ_A:    state_next = ST_SQ_B;
            ST_SQ_B:    state_next = ST_SQ_C;
            ST_SQ_C:    state_next = ST_GM;
            ST_GM:      state_next = ST_ROOT;
            ST_ROOT:    state_next = (cnt_reg == 7'd31) ? ST_DEN_A : ST_ROOT;
            ST_DEN_A:   state_next = ST_DEN_B;
            ST_DEN_B:   state_next = ST_DEN_C;
            ST_DEN_C:   state_next = ST_NUM_A;
            ST_NUM_A:   state_next = ST_NUM_B;
            ST_NUM_B:   state_next = ST_DIV;
            ST_DIV:     state_next = (cnt_reg == 7'd95) ? ST_ACC : ST_DIV;
            ST_ACC:     state_next = axis_reg ? ST_NEXT : ST_NUM_Y;
            ST_NUM_Y:   state_next = ST_NUM_A;
            ST_SAT:     state_next = ST_VEL_X;
            ST_VEL_X:   state_next = ST_VEL_Y;
            ST_VEL_Y:   state_next = ST_POS_X;
            ST_POS_X:   state_next = ST_POS_Y;
            ST_POS_Y:   state_next = ST_POS_END;
            ST_POS_END: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_data.op == OP_UPDATE))
                begin
                    px_reg    <= in_data.pos_x;
                    py_reg    <= in_data.pos_y;
                    vx_reg    <= in_data.vel_x;
                    vy_reg    <= in_data.vel_y;
                    idx_reg   <= in_data.body_index;
                    i_reg     <= '0;
                    lim_reg   <= (32'(cfg.body_count) > MAX_BODIES)
                                 ? CNT_W'(MAX_BODIES) : CNT_W'(cfg.body_count);
                    acc_x_reg <= '0;
                    acc_y_reg <= '0;
                    ovf_reg   <= 1'b0;
                    coin_reg  <= 1'b0;
                end
            end
            ST_NEXT:
            begin
                if ((i_reg < lim_reg) && own)
                begin
                    i_reg <= i_reg + CNT_W'(1);
                end
            end
            ST_DIFF:
            begin
                if (coincident)
                begin
                    coin_reg <= 1'b1;
                    i_reg    <= i_reg + CNT_W'(1);
                end
                ax_reg   <= sh ? mx[32:1] : mx[31:0];
                ay_reg   <= sh ? my[32:1] : my[31:0];
                sh_reg   <= sh;
                dxn_reg  <= dx[32];
                dyn_reg  <= dy[32];
                mass_reg <= mem_rdata[31:0];
            end
            ST_SQ_B: r2_reg <= prod_reg;
            ST_SQ_C: r2_reg <= r2_reg + prod_reg;
            ST_GM:
            begin
                gm_reg     <= prod_reg;
                sq_v_reg   <= r2_reg;
                sq_res_reg <= '0;
                sq_bit_reg <= 64'd1 << 62;
                cnt_reg    <= '0;
            end
            ST_ROOT:
            begin
                sq_v_reg   <= sq_ge ? sq_v_reg - sq_sum : sq_v_reg;
                sq_res_reg <= sq_ge ? (sq_res_reg >> 1) + sq_bit_reg : sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg    <= cnt_reg + 7'd1;
            end
            ST_DEN_B: den_reg <= 98'(prod_reg);
            ST_DEN_C:
            begin
                den_reg  <= (den_reg + (98'(prod_reg) << 32)) << (sh_reg ? 2 : 0);
                axis_reg <= 1'b0;
            end
            ST_NUM_A: num_reg <= 96'(prod_reg);
            ST_NUM_B:
            begin
                num_reg <= num_reg + (96'(prod_reg) << 32);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? 98'(rem_sh - den_ext) : rem_sh[97:0];
                num_reg <= {num_reg[94:0], div_ge};
                cnt_reg <= cnt_reg + 7'd1;
            end
            ST_ACC:
            begin
                if (term_big)
                begin
                    ovf_reg <= 1'b1;
                end
                if (axis_reg)
                begin
                    acc_y_reg <= dyn_reg ? acc_y_reg - $signed(term)
                                         : acc_y_reg + $signed(term);
                    i_reg     <= i_reg + CNT_W'(1);
                end
                else
                begin
                    acc_x_reg <= dxn_reg ? acc_x_reg - $signed(term)
                                         : acc_x_reg + $signed(term);
                end
            end
            ST_NUM_Y: axis_reg <= 1'b1;
            ST_SAT:
            begin
                axo_reg <= sat32(acc_x_reg);
                ayo_reg <= sat32(acc_y_reg);
                if (is_sat(acc_x_reg) || is_sat(acc_y_reg))
                begin
                    ovf_reg <= 1'b1;
                end
            end
            ST_VEL_X: sgn_reg <= axo_reg[31];
            ST_VEL_Y:
            begin
                nvx_reg <= sat32(sum_vx);
                ovf_reg <= ovf_reg | is_sat(sum_vx);
                sgn_reg <= ayo_reg[31];
            end
            ST_POS_X:
            begin
                nvy_reg <= sat32(sum_vy);
                ovf_reg <= ovf_reg | is_sat(sum_vy);
                sgn_reg <= nvx_reg[31];
            end
            ST_POS_Y:
            begin
                npx_reg <= sat32(sum_px);
                ovf_reg <= ovf_reg | is_sat(sum_px);
                sgn_reg <= nvy_reg[31];
            end
            ST_POS_END:
            begin
                npy_reg <= sat32(sum_py);
                ovf_reg <= ovf_reg | is_sat(sum_py);
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_reg.accel_x         <= axo_reg;
                    out_data_reg.accel_y         <= ayo_reg;
                    out_data_reg.new_vel_x       <= nvx_reg;
                    out_data_reg.new_vel_y       <= nvy_reg;
                    out_data_reg.new_pos_x       <= npx_reg;
                    out_data_reg.new_pos_y       <= npy_reg;
                    out_data_reg.overflow_flag   <= ovf_reg;
                    out_data_reg.coincident_flag <= coin_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_update_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_data.op == OP_UPDATE)) |=> (state_reg == ST_NEXT))
        else $error("update request did not start the body walk");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result shown without finishing the sequence");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIFF) |-> (i_reg < lim_reg))
        else $error("table read beyond body count");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |=> (state_reg == ST_DIV) || (state_reg == ST_ACC))
        else $error("divide left early");

endmodule

[tb/nbody_gravity_euler_step_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbody_gravity_euler_step_top_test: self-checking bench for the gravity step
// Loads the body table, runs update requests over several register settings
// and compares every result field against an independent fixed-point
// predictor kept in a scoreboard class. Input idles, output stalls at random.
// ----------------------------------------------------------------------------
module nbody_gravity_euler_step_top_test;
    import nbge_pkg::*;

    localparam int  WATCHDOG_LIMIT = 400000;
    localparam int  HOLD_OFF_CYCLES = 5000;
    localparam int  DRAIN_CYCLES = 20;

    class gravity_scoreboard;
        logic signed [31:0] table_x [MAX_BODIES];
        logic signed [31:0] table_y [MAX_BODIES];
        logic        [31:0] table_mass [MAX_BODIES];
        logic        [10:0] body_count;
        logic        [31:0] gravity_gain;
        logic        [31:0] time_step;
        nbge_rsp_t          expected_motion [$];
        int                 mismatches;
        int                 loads;
        int                 updates;
        int                 coincident_seen;
        int                 overflow_seen;

        function new();
            body_count = '0;
            gravity_gain = '0;
            time_step = '0;
            mismatches = 0;
            loads = 0;
            updates = 0;
            coincident_seen = 0;
            overflow_seen = 0;
        endfunction

        function void set_reg(logic [1:0] index, logic [31:0] value);
            case (index)
                REG_BODY_COUNT:   body_count = value[10:0];
                REG_GRAVITY_GAIN: gravity_gain = value;
                REG_TIME_STEP:    time_step = value;
                default: ;
            endcase
        endfunction

        function bit [63:0] root_floor(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function longint clamp32(longint v, inout bit flag);
            if (v > 64'sd2147483647)
            begin
                flag = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                flag = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint times_step(longint v);
            bit [63:0] mag;
            bit [63:0] p;
            mag = (v < 0) ? 64'(-v) : 64'(v);
            p = (mag * 64'(time_step)) >> 16;
            return (v < 0) ? -longint'(p) : longint'(p);
        endfunction

        function void note_request(nbge_req_t r);
            nbge_rsp_t  exp_rsp;
            longint     dx, dy, acc_x, acc_y, px, py, ax_o, ay_o, nvx, nvy, npx, npy;
            bit [63:0]  mx, my, ax, ay, r2, rt, gm;
            bit [127:0] den, qx, qy;
            bit         sh, ovf, coin;
            int         count;
            if (r.op == OP_LOAD)
            begin
                table_x[r.body_index] = r.pos_x;
                table_y[r.body_index] = r.pos_y;
                table_mass[r.body_index] = r.body_mass_in;
                loads++;
                return;
            end
            updates++;
            px = longint'(r.pos_x);
            py = longint'(r.pos_y);
            acc_x = 0;
            acc_y = 0;
            ovf = 0;
            coin = 0;
            count = (body_count > MAX_BODIES) ? MAX_BODIES : int'(body_count);
            for (int i = 0; i < count; i++)
            begin
                if (i == int'(r.body_index))
                    continue;
                dx = longint'(table_x[i]) - px;
                dy = longint'(table_y[i]) - py;
                if (dx == 0 && dy == 0)
                begin
                    coin = 1;
                    continue;
                end
                mx = (dx < 0) ? 64'(-dx) : 64'(dx);
                my = (dy < 0) ? 64'(-dy) : 64'(dy);
                sh = (mx >= 64'h8000_0000 || my >= 64'h8000_0000);
                ax = mx >> sh;
                ay = my >> sh;
                r2 = ax * ax + ay * ay;
                rt = root_floor(r2);
                den = 128'(r2) * 128'(rt);
                if (sh)
                    den = den << 2;
                gm = 64'(gravity_gain) * 64'(table_mass[i]);
                qx = (128'(gm) * 128'(ax)) / den;
                qy = (128'(gm) * 128'(ay)) / den;
                if (qx > (128'd1 << 40))
                begin
                    qx = 128'd1 << 40;
                    ovf = 1;
                end
                if (qy > (128'd1 << 40))
                begin
                    qy = 128'd1 << 40;
                    ovf = 1;
                end
                acc_x += (dx < 0) ? -longint'(qx[63:0]) : longint'(qx[63:0]);
                acc_y += (dy < 0) ? -longint'(qy[63:0]) : longint'(qy[63:0]);
            end
            ax_o = clamp32(acc_x, ovf);
            ay_o = clamp32(acc_y, ovf);
            nvx = clamp32(longint'(r.vel_x) + times_step(ax_o), ovf);
            nvy = clamp32(longint'(r.vel_y) + times_step(ay_o), ovf);
            npx = clamp32(px + times_step(nvx), ovf);
            npy = clamp32(py + times_step(nvy), ovf);
            exp_rsp.accel_x = ax_o[31:0];
            exp_rsp.accel_y = ay_o[31:0];
            exp_rsp.new_vel_x = nvx[31:0];
            exp_rsp.new_vel_y = nvy[31:0];
            exp_rsp.new_pos_x = npx[31:0];
            exp_rsp.new_pos_y = npy[31:0];
            exp_rsp.overflow_flag = ovf;
            exp_rsp.coincident_flag = coin;
            if (ovf)
                overflow_seen++;
            if (coin)
                coincident_seen++;
            expected_motion.push_back(exp_rsp);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        endtask

        task check_result(nbge_rsp_t got);
            nbge_rsp_t want;
            if (expected_motion.size() == 0)
            begin
                mismatches++;
                $display("%0t result with no request pending: %p", $realtime, got);
                return;
            end
            want = expected_motion.pop_front();
            if (got.accel_x !== want.accel_x)
                report_mismatch("accel_x", got.accel_x, want.accel_x);
            if (got.accel_y !== want.accel_y)
                report_mismatch("accel_y", got.accel_y, want.accel_y);
            if (got.new_vel_x !== want.new_vel_x)
                report_mismatch("new_vel_x", got.new_vel_x, want.new_vel_x);
            if (got.new_vel_y !== want.new_vel_y)
                report_mismatch("new_vel_y", got.new_vel_y, want.new_vel_y);
            if (got.new_pos_x !== want.new_pos_x)
                report_mismatch("new_pos_x", got.new_pos_x, want.new_pos_x);
            if (got.new_pos_y !== want.new_pos_y)
                report_mismatch("new_pos_y", got.new_pos_y, want.new_pos_y);
            if (got.overflow_flag !== want.overflow_flag)
                report_mismatch("overflow_flag", 32'(got.overflow_flag),
                                32'(want.overflow_flag));
            if (got.coincident_flag !== want.coincident_flag)
                report_mismatch("coincident_flag", 32'(got.coincident_flag),
                                32'(want.coincident_flag));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    nbge_req_t          in_data;
    logic               out_valid;
    logic               out_stall;
    nbge_rsp_t          out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    gravity_scoreboard  sb;
    bit                 steady;
    bit                 hold_off_pending;
    int                 quiet_cycles;

    nbody_gravity_euler_step_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(index) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(index, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(logic [10:0] count, logic [31:0] gain, logic [31:0] step);
        write_reg(REG_BODY_COUNT, 32'(count));
        write_reg(REG_GRAVITY_GAIN, gain);
        write_reg(REG_TIME_STEP, step);
    endtask

    task automatic send_request(nbge_req_t r);
        if (!steady && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_motion.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] near_origin();
        return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endfunction

    function automatic nbge_req_t load_req(int idx, logic [31:0] x, logic [31:0] y,
                                           logic [31:0] m);
        nbge_req_t r;
        r.op = OP_LOAD;
        r.body_index = 10'(idx);
        r.pos_x = x;
        r.pos_y = y;
        r.vel_x = $urandom;
        r.vel_y = $urandom;
        r.body_mass_in = m;
        return r;
    endfunction

    function automatic nbge_req_t update_req(int idx, logic [31:0] x, logic [31:0] y,
                                             logic [31:0] vx, logic [31:0] vy);
        nbge_req_t r;
        r.op = OP_UPDATE;
        r.body_index = 10'(idx);
        r.pos_x = x;
        r.pos_y = y;
        r.vel_x = vx;
        r.vel_y = vy;
        r.body_mass_in = $urandom;
        return r;
    endfunction

    function automatic nbge_req_t random_req();
        int          idx;
        int          pick;
        logic [31:0] x, y;
        idx = ($urandom_range(99) < 12) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
        x = ($urandom_range(99) < 20) ? $urandom : near_origin();
        y = ($urandom_range(99) < 20) ? $urandom : near_origin();
        if ($urandom_range(99) < 40)
            return load_req(idx, x, y, ($urandom_range(99) < 25) ? $urandom
                                                                 : $urandom_range(0, 32'h0004_0000));
        if ($urandom_range(99) < 15)
        begin
            pick = $urandom_range(0, 15);
            x = sb.table_x[pick];
            y = sb.table_y[pick];
        end
        return update_req(idx, x, y,
                          ($urandom_range(99) < 20) ? $urandom : near_origin(),
                          ($urandom_range(99) < 20) ? $urandom : near_origin());
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        steady = 1'b0;
        hold_off_pending = 1'b0;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(11'd0, 32'd0, 32'd0);
        send_request(load_req(0, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
        send_request(load_req(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0));
        send_request(load_req(2, 32'd0, 32'd0, 32'h0001_0000));
        send_request(load_req(3, 32'd1, 32'd0, 32'hFFFF_FFFF));
        for (int i = 4; i < 16; i++)
            send_request(load_req(i, near_origin(), near_origin(), $urandom_range(0, 32'h0004_0000)));
        send_request(update_req(1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        drain();

        configure(11'd6, 32'h8000_0000, 32'h0001_0000);
        send_request(update_req(2, 32'd0, 32'd0, 32'd0, 32'd0));
        send_request(update_req(1023, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000));
        send_request(update_req(0, 32'd1, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(update_req(5, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0));
        drain();

        configure(11'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(update_req(9, 32'd2, 32'd0, 32'h8000_0000, 32'h8000_0000));
        send_request(update_req(3, 32'd1, 32'd0, 32'h7FFF_FFFF, 32'd0));
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            configure(11'($urandom_range(1, 8)), $urandom,
                      (phase == 1) ? 32'd0 : ((phase == 2) ? 32'h0001_0000 : $urandom));
            for (int n = 0; n < 135; n++)
            begin
                steady = (phase == 2 && n >= 30 && n < 90);
                if (phase == 1 && n == 10)
                    hold_off_pending = 1'b1;
                send_request(random_req());
            end
            steady = 1'b0;
            drain();
        end

        configure(11'd40, $urandom, $urandom_range(0, 32'h0002_0000));
        for (int i = 16; i < 40; i++)
            send_request(load_req(i, near_origin(), near_origin(), $urandom_range(0, 32'h0004_0000)));
        send_request(update_req(500, near_origin(), near_origin(), $urandom, $urandom));
        drain();

        $display("covered %0d loads and %0d updates, body counts 0 to 40",
                 sb.loads, sb.updates);
        $display("%0d results flagged coincident, %0d flagged overflow",
                 sb.coincident_seen, sb.overflow_seen);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                out_stall <= (!steady && $urandom_range(99) < 26);
                @(posedge clk);
                if (out_valid && !out_stall)
                    sb.check_result(out_data);
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d cycles with no progress", quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
